[src/button_gesture_classifier_unit_defines.svh]
// ----------------------------------------------------------------------------
// Button gesture classifier assertion macros
// Shared concurrent assertion forms for the classifier checkers.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define BGC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Widths, register indexes, reset values and gesture codes.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int unsigned COUNTER_WIDTH_DEF = 10;

    localparam int unsigned DEBOUNCE_W = 8;
    localparam int unsigned DOUBLE_W   = 8;
    localparam int unsigned HOLD_W     = 10;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned GESTURE_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd2;

    // Register reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd5;
    localparam logic [DOUBLE_W-1:0]   DOUBLE_RST   = 8'd30;
    localparam logic [HOLD_W-1:0]     HOLD_RST     = 10'd50;

    typedef enum logic [GESTURE_W-1:0] {
        GESTURE_SINGLE = 2'd0,
        GESTURE_DOUBLE = 2'd1,
        GESTURE_HOLD   = 2'd2
    } t_gesture;

endpackage

[src/bgc_if.sv]
// ----------------------------------------------------------------------------
// Button gesture classifier channels
// Valid/ready channels for button samples and gesture events.
// ----------------------------------------------------------------------------
interface bgc_sample_if;
    logic valid;
    logic ready;
    logic switch_level;

    modport source (output valid, output switch_level, input ready);
    modport sink   (input valid, input switch_level, output ready);
endinterface

interface bgc_gesture_if;
    import bgc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [GESTURE_W-1:0] gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

[src/button_gesture_classifier_unit.sv]
// ----------------------------------------------------------------------------
// Button gesture classifier
// Turns active-low button samples into single click, double click and hold.
// ----------------------------------------------------------------------------
// One sample transaction is taken per clock cycle; its gesture, if any,
// appears on the output channel on the next cycle from a result register.
// The sample side is ready whenever that register is empty or being drained
// in the same cycle, so a downstream stall is the only thing that holds off
// samples. Each sample is one tick: both tick counters advance by one
// (saturating at 2^COUNTER_WIDTH - 1), a fresh press clears the press
// counter, and a release is classified as a hold (press length >= hold_ticks,
// pending clicks dropped) or as a click (length >= debounce_ticks, release
// counter cleared); shorter presses are ignored. Once clicks are pending and
// the release counter reaches double_click_ticks, a single click (one
// pending) or a double click (two or more) is reported. A hold takes the
// output in its tick; at most one gesture leaves per sample. Thresholds are
// written by the user through i_cfg_we / i_cfg_index / i_cfg_data only while
// the block is idle (not enforced); writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module button_gesture_classifier_unit #(
    parameter int unsigned COUNTER_WIDTH = bgc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bgc_sample_if.sink                      i_sample,
    bgc_gesture_if.source                   o_gesture
);
    import bgc_pkg::*;

    // Compare width covers both the counters and the widest threshold.
    localparam int unsigned CMP_W = (COUNTER_WIDTH > HOLD_W) ? COUNTER_WIDTH : HOLD_W;

    typedef logic [COUNTER_WIDTH-1:0] t_cnt;
    typedef logic [CMP_W-1:0]         t_cmp;

    // Configuration registers
    logic [DEBOUNCE_W-1:0] r_debounce;
    logic [DOUBLE_W-1:0]   r_double;
    logic [HOLD_W-1:0]     r_hold;

    // Classifier state
    logic       r_down;
    t_cnt       r_tp;
    t_cnt       r_tr;
    logic [1:0] r_clicks;

    logic       n_down;
    t_cnt       n_tp;
    t_cnt       n_tr;
    logic [1:0] n_clicks;

    // Result register
    logic       r_out_valid;
    t_gesture   r_gesture;
    logic       n_fire;
    t_gesture   n_gesture;

    logic       in_accept;

    assign i_sample.ready    = !r_out_valid || o_gesture.ready;
    assign in_accept         = i_sample.valid && i_sample.ready;
    assign o_gesture.valid   = r_out_valid;
    assign o_gesture.gesture = r_gesture;

    // Next state and result for the sample on the input channel.
    always_comb begin
        logic level_high;
        level_high = i_sample.switch_level;

        // Both counters tick first, saturating.
        n_tp      = (r_tp == '1) ? r_tp : r_tp + t_cnt'(1);
        n_tr      = (r_tr == '1) ? r_tr : r_tr + t_cnt'(1);
        n_down    = r_down;
        n_clicks  = r_clicks;
        n_fire    = 1'b0;
        n_gesture = GESTURE_SINGLE;

        if (!level_high && !r_down) begin
            // Press edge
            n_down = 1'b1;
            n_tp   = '0;
        end else if (level_high && r_down) begin
            // Release edge: classify the press length
            n_down = 1'b0;
            if (t_cmp'(n_tp) >= t_cmp'(r_hold)) begin
                n_fire    = 1'b1;
                n_gesture = GESTURE_HOLD;
                n_clicks  = '0;
            end else if (t_cmp'(n_tp) >= t_cmp'(r_debounce)) begin
                if (n_clicks != 2'd3) begin
                    n_clicks = n_clicks + 2'd1;
                end
                n_tr = '0;
            end
        end

        // Report pending clicks once the double-click window has run out.
        if (!n_fire && (n_clicks != 2'd0) && (t_cmp'(n_tr) >= t_cmp'(r_double))) begin
            n_fire    = 1'b1;
            n_gesture = (n_clicks == 2'd1) ? GESTURE_SINGLE : GESTURE_DOUBLE;
            n_clicks  = '0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_double   <= DOUBLE_RST;
            r_hold     <= HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[DEBOUNCE_W-1:0];
                CFG_DOUBLE:   r_double   <= i_cfg_data[DOUBLE_W-1:0];
                CFG_HOLD:     r_hold     <= i_cfg_data[HOLD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Classifier state, updated once per accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down   <= 1'b0;
            r_tp     <= '0;
            r_tr     <= '0;
            r_clicks <= '0;
        end else if (in_accept) begin
            r_down   <= n_down;
            r_tp     <= n_tp;
            r_tr     <= n_tr;
            r_clicks <= n_clicks;
        end
    end

    // Output register: loads on accept, drains when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= n_fire;
        end else if (o_gesture.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_fire) begin
            r_gesture <= n_gesture;
        end
    end

endmodule

[src/bgc_checker.sv]
// ----------------------------------------------------------------------------
// Button gesture classifier checker
// Port-level assertions on sample and gesture traffic, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_unit_defines.svh"

module bgc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [bgc_pkg::GESTURE_W-1:0]   i_gesture
);
    import bgc_pkg::*;

    // Sample side is never blocked while the result register is free.
    `BGC_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, (!i_out_valid || i_out_ready), i_in_ready, "sample side stalled with free result register")

    // A gesture only appears right after a sample transaction.
    `BGC_ASSERT_IMP(a_result_needs_sample, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready), "gesture without a sample")

    // A drained result is not repeated without a new sample.
    `BGC_ASSERT_NEXT(a_no_repeat, i_clk, i_rst_n, (i_out_valid && i_out_ready && !(i_in_valid && i_in_ready)), !i_out_valid, "gesture repeated")

    // A stalled gesture holds its code.
    `BGC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready), (i_out_valid && $stable(i_gesture)), "stalled gesture changed")

endmodule

bind button_gesture_classifier_unit bgc_checker u_bgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_gesture.valid),
    .i_out_ready (o_gesture.ready),
    .i_gesture   (o_gesture.gesture)
);
